// ===== rtl/distance_vector_route_engine_unit_macros.svh =====
// Assertion helpers for the route engine.
`ifndef DISTANCE_VECTOR_ROUTE_ENGINE_UNIT_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define DVR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DVR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dvr_pkg.sv =====
package dvr_pkg;

   localparam int ROUTERS_DEF       = 8;
   localparam int INFINITY_COST_DEF = 1000;

   localparam int OP_W      = 2;
   localparam int ID_W      = 3;
   localparam int COST_IN_W = 10;
   localparam int ACT_W     = 2;

   localparam logic [OP_W-1:0] OP_LINK   = 2'd0;
   localparam logic [OP_W-1:0] OP_VECTOR = 2'd1;
   localparam logic [OP_W-1:0] OP_ROUTE  = 2'd2;

   localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DELIVER = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd2;
   localparam logic [ACT_W-1:0] ACT_ACK     = 2'd3;

   localparam logic MSG_DATA = 1'b0;
   localparam logic MSG_ACK  = 1'b1;

endpackage

// ===== rtl/dvr_table.sv =====
module dvr_table #(
   parameter int IDX_W         = 3,
   parameter int COST_W        = 10,
   parameter int INFINITY_COST = 1000
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_row,
   input  logic [IDX_W-1:0]  wr_col,
   input  logic [COST_W-1:0] wr_data,
   input  logic [IDX_W-1:0]  a_row,
   input  logic [IDX_W-1:0]  a_col,
   input  logic              a_oob,
   output logic [COST_W-1:0] a_data,
   input  logic [IDX_W-1:0]  b_row,
   input  logic [IDX_W-1:0]  b_col,
   input  logic              b_oob,
   output logic [COST_W-1:0] b_data
);

   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam logic [COST_W-1:0] INF_C = COST_W'(INFINITY_COST);

   logic [COST_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;
   logic [COST_W-1:0] a_q_ff, b_q_ff;
   logic              a_hit_ff, b_hit_ff, a_diag_ff, b_diag_ff, a_oob_ff, b_oob_ff;

   assign wr_addr = {wr_row, wr_col};
   assign a_addr  = {a_row, a_col};
   assign b_addr  = {b_row, b_col};

   // entries never written read as the reset pattern: 0 on the diagonal, infinity elsewhere
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      a_q_ff    <= mem[a_addr];
      b_q_ff    <= mem[b_addr];
      a_hit_ff  <= valid_ff[a_addr];
      b_hit_ff  <= valid_ff[b_addr];
      a_diag_ff <= (a_row == a_col);
      b_diag_ff <= (b_row == b_col);
      a_oob_ff  <= a_oob;
      b_oob_ff  <= b_oob;
   end

   assign a_data = a_oob_ff ? INF_C : a_hit_ff ? a_q_ff : a_diag_ff ? '0 : INF_C;
   assign b_data = b_oob_ff ? INF_C : b_hit_ff ? b_q_ff : b_diag_ff ? '0 : INF_C;

endmodule

// ===== rtl/distance_vector_route_engine_unit.sv =====
// Distance-vector route engine.
// Input channel req_*: one item per transfer (link cost, neighbor vector element, or a
// message header). Result channel rsp_*: exactly one result per item, in order.
// csr_write_enable/csr_write_data set own_id; write only while the block is idle.
// Processing per item: a link cost or a vector element without last flag is stored
// directly; a header is answered either without a table scan or after a next-hop scan
// (one table pair read per cycle); the last vector element starts a relaxation that
// sweeps the table pair by pair, then reloads the own row from the distance vector.
// One item is in flight at a time; req_stall is low only when the engine is idle.
// Throughput is set by the one item in flight; sweeps use both cost table read ports.
// The result sits in an output register, so the next item is taken while a result
// waits; a stalled result holds, and the engine then waits to post its next one.
// Reset (synchronous) clears own_id and marks every table and vector entry unwritten,
// so they read as infinity (0 on table diagonal and own vector entry); no clearing pass is needed.
`include "distance_vector_route_engine_unit_macros.svh"

module distance_vector_route_engine_unit #(
   parameter int ROUTERS       = dvr_pkg::ROUTERS_DEF,
   parameter int INFINITY_COST = dvr_pkg::INFINITY_COST_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [dvr_pkg::ID_W-1:0]      csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dvr_pkg::OP_W-1:0]      req_operation,
   input  logic [dvr_pkg::ID_W-1:0]      req_source_router,
   input  logic [dvr_pkg::ID_W-1:0]      req_target_index,
   input  logic [dvr_pkg::COST_IN_W-1:0] req_cost,
   input  logic                          req_message_kind,
   input  logic                          req_last_element,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dvr_pkg::ACT_W-1:0]     rsp_action,
   output logic [dvr_pkg::ID_W-1:0]      rsp_next_hop
);

   import dvr_pkg::*;

   localparam int IDX_W    = $clog2(ROUTERS);
   localparam int COST_W   = $clog2(INFINITY_COST + 1);
   localparam int SUM_W    = COST_W + 1;
   localparam int DV_DEPTH = 1 << IDX_W;
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ROUTERS - 1);
   localparam logic [COST_W-1:0] INF_C    = COST_W'(INFINITY_COST);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_OP     = 4'd1;
   localparam logic [3:0] S_RELAX  = 4'd2;
   localparam logic [3:0] S_RDRAIN = 4'd3;
   localparam logic [3:0] S_COPY   = 4'd4;
   localparam logic [3:0] S_CDRAIN = 4'd5;
   localparam logic [3:0] S_HDR    = 4'd6;
   localparam logic [3:0] S_SCAN   = 4'd7;
   localparam logic [3:0] S_SDRAIN = 4'd8;
   localparam logic [3:0] S_RESP   = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [ID_W-1:0]   own_ff, own_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [ID_W-1:0]   src_ff, src_in, tgt_ff, tgt_in, dest_ff, dest_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic              kind_ff, kind_in, last_ff, last_in;
   logic [IDX_W-1:0]  cnt_i_ff, cnt_i_in, cnt_j_ff, cnt_j_in;
   logic              tag_valid_ff, tag_valid_in;
   logic [IDX_W-1:0]  tag_i_ff, tag_i_in, tag_j_ff, tag_j_in;
   logic [COST_W-1:0] best_ff, best_in, dvd_ff, dvd_in;
   logic              desc_ff, desc_in, scan_first_ff, scan_first_in, found_ff, found_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [ID_W-1:0]   hop_ff, hop_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]  rsp_action_ff, rsp_action_in;
   logic [ID_W-1:0]   rsp_hop_ff, rsp_hop_in;

   // table ports
   logic              tbl_we;
   logic [IDX_W-1:0]  tbl_wrow, tbl_wcol, a_row, a_col, b_row, b_col;
   logic [COST_W-1:0] tbl_wdata, a_data, b_data;
   logic              a_oob, b_oob;

   // distance vector memory
   logic [COST_W-1:0] dv_mem [DV_DEPTH];
   logic [DV_DEPTH-1:0] dv_valid_ff, dv_valid_in;
   logic              dv_we, dv_roob;
   logic [IDX_W-1:0]  dv_waddr, dv_raddr;
   logic [COST_W-1:0] dv_wdata, dv_q_ff, dv_value;
   logic              dv_hit_ff, dv_own_ff, dv_oob_ff;

   logic [IDX_W-1:0]  own_idx, src_idx, tgt_idx, dest_idx;
   logic              own_ok, src_ok, tgt_ok, dest_ok;
   logic [ID_W-1:0]   hdr_dest;
   logic              hdr_deliver;
   logic [SUM_W-1:0]  sum;
   logic [COST_W-1:0] base, cand;
   logic              j_is_own, i_is_own, i_is_dest, hop_hit;
   logic              req_xfer;

   assign own_idx  = IDX_W'(own_ff);
   assign src_idx  = IDX_W'(src_ff);
   assign tgt_idx  = IDX_W'(tgt_ff);
   assign dest_idx = IDX_W'(dest_ff);
   assign own_ok   = (32'(own_ff) < ROUTERS);
   assign src_ok   = (32'(src_ff) < ROUTERS);
   assign tgt_ok   = (32'(tgt_ff) < ROUTERS);
   assign dest_ok  = (32'(dest_ff) < ROUTERS);

   assign hdr_deliver = (kind_ff == MSG_DATA) && (tgt_ff == own_ff);
   assign hdr_dest    = hdr_deliver ? src_ff : tgt_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   assign dv_value = dv_oob_ff ? INF_C : dv_own_ff ? '0 : dv_hit_ff ? dv_q_ff : INF_C;

   // one table pair per cycle: a = table[row][col], b = table[own][row]
   assign sum       = SUM_W'(a_data) + SUM_W'(b_data);
   assign j_is_own  = own_ok && (tag_j_ff == own_idx);
   assign i_is_own  = own_ok && (tag_i_ff == own_idx);
   assign i_is_dest = dest_ok && (tag_i_ff == dest_idx);
   assign base      = (tag_j_ff == '0) ? dv_value : best_ff;
   assign cand      = (!j_is_own && (sum < SUM_W'(base))) ? COST_W'(sum) : base;
   assign hop_hit   = !i_is_own && !i_is_dest && (sum == SUM_W'(dvd_ff));

   always_comb begin
      state_in      = state_ff;
      own_in        = csr_write_enable ? csr_write_data : own_ff;
      op_in         = op_ff;
      src_in        = src_ff;
      tgt_in        = tgt_ff;
      cost_in       = cost_ff;
      kind_in       = kind_ff;
      last_in       = last_ff;
      dest_in       = dest_ff;
      cnt_i_in      = cnt_i_ff;
      cnt_j_in      = cnt_j_ff;
      tag_valid_in  = 1'b0;
      tag_i_in      = tag_i_ff;
      tag_j_in      = tag_j_ff;
      best_in       = best_ff;
      dvd_in        = dvd_ff;
      desc_in       = desc_ff;
      scan_first_in = scan_first_ff;
      found_in      = found_ff;
      act_in        = act_ff;
      hop_in        = hop_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_action_in = rsp_action_ff;
      rsp_hop_in    = rsp_hop_ff;

      tbl_we    = 1'b0;
      tbl_wrow  = own_idx;
      tbl_wcol  = tgt_idx;
      tbl_wdata = cost_ff;
      a_row     = cnt_j_ff;
      a_col     = cnt_i_ff;
      a_oob     = 1'b0;
      b_row     = own_idx;
      b_col     = cnt_j_ff;
      b_oob     = !own_ok;
      dv_we     = 1'b0;
      dv_waddr  = tgt_idx;
      dv_wdata  = cost_ff;
      dv_raddr  = cnt_i_ff;
      dv_roob   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_operation;
               src_in  = req_source_router;
               tgt_in  = req_target_index;
               kind_in = req_message_kind;
               last_in = req_last_element;
               if (32'(req_cost) > INFINITY_COST) begin
                  cost_in = INF_C;
               end else begin
                  cost_in = COST_W'(req_cost);
               end
               state_in = S_OP;
            end
         end
         S_OP: begin
            act_in = ACT_NONE;
            hop_in = '0;
            unique case (op_ff)
               OP_LINK: begin
                  if (tgt_ok && (tgt_ff != own_ff)) begin
                     dv_we  = 1'b1;
                     tbl_we = own_ok;
                  end
                  state_in = S_RESP;
               end
               OP_VECTOR: begin
                  tbl_we   = src_ok && tgt_ok;
                  tbl_wrow = src_idx;
                  if (last_ff) begin
                     cnt_i_in = '0;
                     cnt_j_in = '0;
                     state_in = S_RELAX;
                  end else begin
                     state_in = S_RESP;
                  end
               end
               OP_ROUTE: begin
                  state_in = S_HDR;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_RELAX: begin
            tag_valid_in = 1'b1;
            tag_i_in     = cnt_i_ff;
            tag_j_in     = cnt_j_ff;
            if (cnt_j_ff == LAST_IDX) begin
               cnt_j_in = '0;
               if (cnt_i_ff == LAST_IDX) begin
                  state_in = S_RDRAIN;
               end else begin
                  cnt_i_in = cnt_i_ff + 1'b1;
               end
            end else begin
               cnt_j_in = cnt_j_ff + 1'b1;
            end
         end
         S_RDRAIN: begin
            cnt_i_in = '0;
            state_in = S_COPY;
         end
         S_COPY: begin
            tag_valid_in = 1'b1;
            tag_i_in     = cnt_i_ff;
            if (cnt_i_ff == LAST_IDX) begin
               state_in = S_CDRAIN;
            end else begin
               cnt_i_in = cnt_i_ff + 1'b1;
            end
         end
         S_CDRAIN: begin
            state_in = S_RESP;
         end
         S_HDR: begin
            if ((kind_ff == MSG_ACK) && (tgt_ff == own_ff)) begin
               act_in   = ACT_ACK;
               hop_in   = '0;
               state_in = S_RESP;
            end else begin
               act_in   = hdr_deliver ? ACT_DELIVER : ACT_FORWARD;
               dest_in  = hdr_dest;
               hop_in   = hdr_dest;
               found_in = 1'b0;
               dv_raddr = IDX_W'(hdr_dest);
               dv_roob  = !(32'(hdr_dest) < ROUTERS);
               if (hdr_dest == own_ff) begin
                  state_in = S_RESP;
               end else begin
                  desc_in       = (hdr_dest < own_ff);
                  cnt_i_in      = (hdr_dest < own_ff) ? LAST_IDX : '0;
                  scan_first_in = 1'b1;
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            a_row         = cnt_i_ff;
            a_col         = dest_idx;
            a_oob         = !dest_ok;
            b_col         = cnt_i_ff;
            tag_valid_in  = 1'b1;
            tag_i_in      = cnt_i_ff;
            scan_first_in = 1'b0;
            // vector read issued from the header state lands here
            if (scan_first_ff) begin
               dvd_in = dv_value;
            end
            if (desc_ff) begin
               if (cnt_i_ff == '0) begin
                  state_in = S_SDRAIN;
               end else begin
                  cnt_i_in = cnt_i_ff - 1'b1;
               end
            end else begin
               if (cnt_i_ff == LAST_IDX) begin
                  state_in = S_SDRAIN;
               end else begin
                  cnt_i_in = cnt_i_ff + 1'b1;
               end
            end
         end
         S_SDRAIN: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = act_ff;
               rsp_hop_in    = hop_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // read data stage: data for the tag issued in the previous cycle
      if (tag_valid_ff) begin
         if ((state_ff == S_RELAX) || (state_ff == S_RDRAIN)) begin
            best_in = cand;
            if ((tag_j_ff == LAST_IDX) && !i_is_own) begin
               dv_we    = 1'b1;
               dv_waddr = tag_i_ff;
               dv_wdata = cand;
            end
         end else if ((state_ff == S_COPY) || (state_ff == S_CDRAIN)) begin
            tbl_we    = own_ok;
            tbl_wrow  = own_idx;
            tbl_wcol  = tag_i_ff;
            tbl_wdata = dv_value;
         end else if (!found_ff && hop_hit) begin
            found_in = 1'b1;
            hop_in   = ID_W'(tag_i_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         own_ff        <= '0;
         tag_valid_ff  <= 1'b0;
         scan_first_ff <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         own_ff        <= own_in;
         tag_valid_ff  <= tag_valid_in;
         scan_first_ff <= scan_first_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      src_ff        <= src_in;
      tgt_ff        <= tgt_in;
      cost_ff       <= cost_in;
      kind_ff       <= kind_in;
      last_ff       <= last_in;
      dest_ff       <= dest_in;
      cnt_i_ff      <= cnt_i_in;
      cnt_j_ff      <= cnt_j_in;
      tag_i_ff      <= tag_i_in;
      tag_j_ff      <= tag_j_in;
      best_ff       <= best_in;
      dvd_ff        <= dvd_in;
      desc_ff       <= desc_in;
      act_ff        <= act_in;
      hop_ff        <= hop_in;
      rsp_action_ff <= rsp_action_in;
      rsp_hop_ff    <= rsp_hop_in;
   end

   // distance vector: unwritten entries read as infinity, own entry as 0
   always_comb begin
      dv_valid_in = dv_valid_ff;
      if (dv_we) begin
         dv_valid_in[dv_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff <= '0;
      end else begin
         dv_valid_ff <= dv_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_we) begin
         dv_mem[dv_waddr] <= dv_wdata;
      end
      dv_q_ff   <= dv_mem[dv_raddr];
      dv_hit_ff <= dv_valid_ff[dv_raddr];
      dv_own_ff <= own_ok && !dv_roob && (dv_raddr == own_idx);
      dv_oob_ff <= dv_roob;
   end

   dvr_table #(
      .IDX_W         (IDX_W),
      .COST_W        (COST_W),
      .INFINITY_COST (INFINITY_COST)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_we),
      .wr_row  (tbl_wrow),
      .wr_col  (tbl_wcol),
      .wr_data (tbl_wdata),
      .a_row   (a_row),
      .a_col   (a_col),
      .a_oob   (a_oob),
      .a_data  (a_data),
      .b_row   (b_row),
      .b_col   (b_col),
      .b_oob   (b_oob),
      .b_data  (b_data)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_action   = rsp_action_ff;
   assign rsp_next_hop = rsp_hop_ff;

   `DVR_ASSERT_IMP(a_tbl_write_quiet, clock, reset, tbl_we, !((state_ff == S_RELAX) || (state_ff == S_SCAN) || (state_ff == S_HDR)), "table written during a read sweep")
   `DVR_ASSERT_IMP(a_tag_in_sweep, clock, reset, tag_valid_ff, (state_ff == S_RELAX) || (state_ff == S_RDRAIN) || (state_ff == S_COPY) || (state_ff == S_CDRAIN) || (state_ff == S_SCAN) || (state_ff == S_SDRAIN), "read tag outside a sweep")
   `DVR_ASSERT_IMP(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_RESP, "result posted outside response state")
   `DVR_ASSERT_NXT(a_xfer_starts_op, clock, reset, req_xfer, (state_ff == S_OP) && !tag_valid_ff, "accepted item did not start execution")

endmodule

// ===== dv/distance_vector_route_engine_unit_tb.sv =====
module distance_vector_route_engine_unit_tb;
   import dvr_pkg::*;

   localparam int NODES          = ROUTERS_DEF;
   localparam int UNREACH        = INFINITY_COST_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int TAIL_CYCLES    = NODES * NODES + NODES + 8;

   // operation code that the block answers with no action
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef logic [ID_W-1:0]      node_type;
   typedef logic [10:0]          path_cost_type;
   typedef logic [COST_IN_W-1:0] wire_cost_type;

   typedef struct packed {
      logic [OP_W-1:0] operation;
      node_type        source_router;
      node_type        target_index;
      wire_cost_type   cost;
      logic            message_kind;
      logic            last_element;
   } route_req_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      node_type         next_hop;
   } route_answer_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_write_enable = 1'b0;
   node_type         csr_write_data = '0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [OP_W-1:0]  req_operation = '0;
   node_type         req_source_router = '0;
   node_type         req_target_index = '0;
   wire_cost_type    req_cost = '0;
   logic             req_message_kind = 1'b0;
   logic             req_last_element = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [ACT_W-1:0] rsp_action;
   node_type         rsp_next_hop;

   distance_vector_route_engine_unit uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_source_router(req_source_router),
      .req_target_index (req_target_index),
      .req_cost         (req_cost),
      .req_message_kind (req_message_kind),
      .req_last_element (req_last_element),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_action       (rsp_action),
      .rsp_next_hop     (rsp_next_hop)
   );

   // shadow copy of the router state
   path_cost_type cost_table [NODES][NODES];
   path_cost_type dist_vec [NODES];
   node_type      my_id;

   route_answer_type answers_q[$];
   int               errors = 0;
   int               items_sent = 0;
   int               answers_checked = 0;
   int               relax_passes = 0;
   int               action_seen [4] = '{0, 0, 0, 0};
   logic             idle_on = 1'b1;
   logic             long_hold_req = 1'b0;
   node_type         mid_id = '0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void clear_tables();
      int r, c;
      my_id = '0;
      for (r = 0; r < NODES; r++) begin
         dist_vec[r] = path_cost_type'(UNREACH);
         for (c = 0; c < NODES; c++)
            cost_table[r][c] = (r == c) ? path_cost_type'(0) : path_cost_type'(UNREACH);
      end
   endfunction

   function automatic path_cost_type vec_cost(node_type i);
      return (i == my_id) ? path_cost_type'(0) : dist_vec[i];
   endfunction

   // Bellman-Ford pass: costs only fall, own index skipped, then own row reloaded
   function automatic void relax_vector();
      int i, j;
      path_cost_type best;
      logic [11:0] via;
      for (i = 0; i < NODES; i++) begin
         if (i != my_id) begin
            best = dist_vec[i];
            for (j = 0; j < NODES; j++) begin
               via = cost_table[j][i] + cost_table[my_id][j];
               if (j != my_id && via < best)
                  best = via[10:0];
            end
            dist_vec[i] = best;
         end
      end
      for (i = 0; i < NODES; i++)
         cost_table[my_id][i] = vec_cost(node_type'(i));
   endfunction

   function automatic logic hop_fits(node_type i, node_type dest);
      logic [11:0] via;
      via = cost_table[i][dest] + cost_table[my_id][i];
      return i != my_id && i != dest && via == 12'(vec_cost(dest));
   endfunction

   function automatic node_type pick_next_hop(node_type dest);
      int i;
      if (dest > my_id) begin
         for (i = 0; i < NODES; i++)
            if (hop_fits(node_type'(i), dest))
               return node_type'(i);
      end else if (dest < my_id) begin
         for (i = NODES - 1; i >= 0; i--)
            if (hop_fits(node_type'(i), dest))
               return node_type'(i);
      end
      return dest;
   endfunction

   function automatic route_answer_type predict_answer(route_req_type rq);
      route_answer_type ans;
      path_cost_type c;
      ans.action   = ACT_NONE;
      ans.next_hop = '0;
      c = (rq.cost > UNREACH) ? path_cost_type'(UNREACH) : path_cost_type'(rq.cost);
      case (rq.operation)
         OP_LINK: begin
            if (rq.target_index != my_id) begin
               dist_vec[rq.target_index]          = c;
               cost_table[my_id][rq.target_index] = c;
            end
         end
         OP_VECTOR: begin
            cost_table[rq.source_router][rq.target_index] = c;
            if (rq.last_element) begin
               relax_vector();
               relax_passes++;
            end
         end
         OP_ROUTE: begin
            if (rq.target_index != my_id) begin
               ans.action   = ACT_FORWARD;
               ans.next_hop = pick_next_hop(rq.target_index);
            end else if (rq.message_kind == MSG_DATA) begin
               ans.action   = ACT_DELIVER;
               ans.next_hop = pick_next_hop(rq.source_router);
            end else begin
               ans.action = ACT_ACK;
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic route_req_type make_req(logic [OP_W-1:0] op, node_type src,
                                              node_type tgt, wire_cost_type cost,
                                              logic kind, logic last);
      route_req_type rq;
      rq.operation     = op;
      rq.source_router = src;
      rq.target_index  = tgt;
      rq.cost          = cost;
      rq.message_kind  = kind;
      rq.last_element  = last;
      return rq;
   endfunction

   // mostly small costs so relaxation finds real paths, sometimes the extremes
   function automatic wire_cost_type pick_cost();
      case ($urandom_range(0, 7))
         0: return wire_cost_type'(UNREACH);
         1: return wire_cost_type'($urandom_range(UNREACH + 1, 1023));
         2: return wire_cost_type'($urandom_range(0, 1023));
         3: return '0;
         default: return wire_cost_type'($urandom_range(1, 20));
      endcase
   endfunction

   task automatic send_req(route_req_type rq);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= rq.operation;
      req_source_router <= rq.source_router;
      req_target_index  <= rq.target_index;
      req_cost          <= rq.cost;
      req_message_kind  <= rq.message_kind;
      req_last_element  <= rq.last_element;
      do
         @(posedge clock);
      while (!(req_valid && !req_stall));
      answers_q.push_back(predict_answer(rq));
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (answers_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_own_id(node_type id);
      csr_write_enable <= 1'b1;
      csr_write_data   <= id;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      my_id = id;
   endtask

   // neighbor vectors (some cut short), link costs, headers and a little noise
   task automatic drive_traffic(int count);
      int sent, pick, t, stop, offset;
      node_type nb, tgt;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 9);
         if (pick <= 3) begin
            nb = ($urandom_range(0, 7) == 0) ? node_type'($urandom_range(0, 7))
                                              : node_type'(my_id + $urandom_range(1, 7));
            stop   = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : NODES;
            offset = $urandom_range(0, 7);
            for (t = 0; t < stop; t++)
               send_req(make_req(OP_VECTOR, nb, node_type'(t + offset), pick_cost(),
                                 1'($urandom), 1'(t == NODES - 1)));
            sent += stop;
         end else if (pick <= 5) begin
            tgt = ($urandom_range(0, 5) == 0) ? my_id : node_type'($urandom_range(0, 7));
            send_req(make_req(OP_LINK, node_type'($urandom), tgt, pick_cost(),
                              1'($urandom), 1'($urandom)));
            sent++;
         end else if (pick <= 8) begin
            tgt = ($urandom_range(0, 2) == 0) ? my_id : node_type'($urandom_range(0, 7));
            send_req(make_req(OP_ROUTE, node_type'($urandom), tgt,
                              wire_cost_type'($urandom), 1'($urandom), 1'($urandom)));
            sent++;
         end else begin
            send_req(make_req(OP_W'($urandom), node_type'($urandom), node_type'($urandom),
                              wire_cost_type'($urandom), 1'($urandom), 1'($urandom)));
            sent++;
         end
      end
   endtask

   task automatic test_directed_cases();
      wire_cost_type vec_costs [NODES] = '{10'd3, 10'd1000, 10'd1, 10'd7, 10'd0, 10'd0,
                                           10'd6, 10'd1023};
      int t;
      write_own_id(node_type'(3));
      // empty table: every lookup falls back to the destination itself
      send_req(make_req(OP_ROUTE, 3'd0, 3'd3, 10'd0, MSG_DATA, 1'b0));
      send_req(make_req(OP_ROUTE, 3'd5, 3'd3, 10'd0, MSG_ACK, 1'b0));
      send_req(make_req(OP_ROUTE, 3'd1, 3'd7, 10'd0, MSG_DATA, 1'b0));
      // link to self is ignored; 1023 saturates to infinity
      send_req(make_req(OP_LINK, 3'd0, 3'd3, 10'd5, MSG_DATA, 1'b0));
      send_req(make_req(OP_LINK, 3'd0, 3'd1, 10'd4, MSG_DATA, 1'b0));
      send_req(make_req(OP_LINK, 3'd7, 3'd5, 10'd2, MSG_ACK, 1'b1));
      send_req(make_req(OP_LINK, 3'd0, 3'd0, 10'd1023, MSG_DATA, 1'b0));
      send_req(make_req(OP_LINK, 3'd0, 3'd7, 10'd0, MSG_DATA, 1'b0));
      for (t = 0; t < NODES; t++)
         send_req(make_req(OP_VECTOR, 3'd5, node_type'(t), vec_costs[t], MSG_DATA,
                           1'(t == NODES - 1)));
      // own row written as if it came from a neighbor
      send_req(make_req(OP_VECTOR, 3'd3, 3'd6, 10'd9, MSG_DATA, 1'b0));
      send_req(make_req(OP_VECTOR, 3'd7, 3'd0, 10'd0, MSG_DATA, 1'b1));
      send_req(make_req(OP_ROUTE, 3'd6, 3'd0, 10'd0, MSG_DATA, 1'b0));
      send_req(make_req(OP_ROUTE, 3'd6, 3'd6, 10'd0, MSG_ACK, 1'b0));
      send_req(make_req(OP_ROUTE, 3'd7, 3'd3, 10'd0, MSG_DATA, 1'b0));
      send_req(make_req(OP_ROUTE, 3'd0, 3'd2, 10'd1023, MSG_ACK, 1'b1));
      send_req(make_req(OP_UNUSED, 3'd7, 3'd7, 10'd1023, MSG_ACK, 1'b1));
   endtask

   task automatic test_route_traffic();
      mid_id = node_type'($urandom_range(1, NODES - 2));
      wait_for_drain();
      write_own_id('0);
      drive_traffic(100);
      wait_for_drain();
      write_own_id(node_type'(NODES - 1));
      drive_traffic(100);
      wait_for_drain();
      write_own_id(mid_id);
      drive_traffic(90);
   endtask

   // receiver holds off while the sender keeps offering, then the sender drains
   task automatic test_backpressure();
      wait_for_drain();
      long_hold_req = 1'b1;
      drive_traffic(14);
      wait_for_drain();
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      drive_traffic(70);
   endtask

   initial begin : rsp_stall_gen
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : result_check
      route_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_q.size() == 0) begin
            errors++;
            $display("%0t: result transfer with nothing expected: action=%0d next_hop=%0d",
                     $time, rsp_action, rsp_next_hop);
         end else begin
            want = answers_q.pop_front();
            answers_checked++;
            action_seen[want.action]++;
            if (rsp_action !== want.action) begin
               errors++;
               $display("%0t: action mismatch: expected %0d, got %0d",
                        $time, want.action, rsp_action);
            end
            if (rsp_next_hop !== want.next_hop) begin
               errors++;
               $display("%0t: next_hop mismatch: expected %0d, got %0d",
                        $time, want.next_hop, rsp_next_hop);
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("distance_vector_route_engine_unit_tb failed");
      $finish;
   end

   initial begin
      clear_tables();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_route_traffic();
      test_backpressure();
      test_steady_stream();
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d items with own_id 3, 0, %0d and %0d; %0d relaxation passes.",
               items_sent, NODES - 1, mid_id, relax_passes);
      $display("Checked %0d results (none %0d, deliver %0d, forward %0d, ack %0d).",
               answers_checked, action_seen[0], action_seen[1], action_seen[2],
               action_seen[3]);
      if (errors == 0)
         $display("distance_vector_route_engine_unit_tb passed");
      else
         $display("distance_vector_route_engine_unit_tb failed");
      $finish;
   end

endmodule
